### rtl/one_sided_spring_force_unit_assert.svh
// ----------------------------------------------------------------------------
// one_sided_spring_force_unit_assert.svh
// Assertion macros for the spring force unit, clocked on i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ONE_SIDED_SPRING_FORCE_UNIT_ASSERT_SVH
`define ONE_SIDED_SPRING_FORCE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define OSSF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spring force unit: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define OSSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spring force unit: next-cycle check failed");

`endif

### rtl/ossf_pkg.sv
// ----------------------------------------------------------------------------
// ossf_pkg
// Shared constants of the one-sided spring force unit.
// ----------------------------------------------------------------------------
package ossf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int K_WIDTH    = 32;
    localparam int REST_WIDTH = 31;
    localparam int CFG_WIDTH  = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPRING_STIFFNESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH      = 1'd1;

    localparam logic [K_WIDTH-1:0]    K_RESET    = 32'd65536;
    localparam logic [REST_WIDTH-1:0] REST_RESET = 31'd65536;

endpackage

### rtl/ossf_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// ossf_sqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ossf_sqrt_pipe #(
    parameter int LW  = 33,
    parameter int SBW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [2*LW-1:0]   i_rad,
    input  logic [SBW-1:0]    i_sb,
    output logic              o_vld,
    output logic [LW-1:0]     o_root,
    output logic [SBW-1:0]    o_sb
);

    localparam int SW = 2 * LW;
    localparam int RMW = LW + 2;

    logic            w_vld  [0:LW];
    logic [SW-1:0]   w_rad  [0:LW];
    logic [RMW-1:0]  w_rem  [0:LW];
    logic [LW-1:0]   w_root [0:LW];
    logic [SBW-1:0]  w_sb   [0:LW];

    logic            r_vld  [0:LW-1];
    logic [SW-1:0]   r_rad  [0:LW-1];
    logic [RMW-1:0]  r_rem  [0:LW-1];
    logic [LW-1:0]   r_root [0:LW-1];
    logic [SBW-1:0]  r_sb   [0:LW-1];

    assign w_vld[0]  = i_vld;
    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_sb[0]   = i_sb;

    for (genvar j = 0; j < LW; j++) begin : g_stage
        logic [RMW+1:0] w_t;
        logic [RMW+1:0] w_trial;
        logic           w_ge;
        logic [RMW+1:0] w_diff;

        assign w_t     = {w_rem[j], w_rad[j][SW-1 -: 2]};
        assign w_trial = {2'b00, w_root[j], 2'b01};
        assign w_ge    = (w_t >= w_trial);
        assign w_diff  = w_t - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j]  <= {w_rad[j][SW-3:0], 2'b00};
                r_rem[j]  <= w_ge ? w_diff[RMW-1:0] : w_t[RMW-1:0];
                r_root[j] <= {w_root[j][LW-2:0], w_ge};
                r_sb[j]   <= w_sb[j];
            end
        end

        assign w_vld[j+1]  = r_vld[j];
        assign w_rad[j+1]  = r_rad[j];
        assign w_rem[j+1]  = r_rem[j];
        assign w_root[j+1] = r_root[j];
        assign w_sb[j+1]   = r_sb[j];
    end

    assign o_vld  = w_vld[LW];
    assign o_root = w_root[LW];
    assign o_sb   = w_sb[LW];

endmodule

### rtl/ossf_div_pipe.sv
// ----------------------------------------------------------------------------
// ossf_div_pipe
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ossf_div_pipe #(
    parameter int LW  = 33,
    parameter int QW  = 49,
    parameter int SBW = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic [2:0][LW+QW-1:0]    i_num,
    input  logic [LW-1:0]            i_den,
    input  logic [SBW-1:0]           i_sb,
    output logic                     o_vld,
    output logic [2:0][QW-1:0]       o_quo,
    output logic [SBW-1:0]           o_sb
);

    localparam int NW = LW + QW;

    logic                  w_vld [0:QW];
    logic [2:0][NW-1:0]    w_w   [0:QW];
    logic [LW-1:0]         w_den [0:QW];
    logic [SBW-1:0]        w_sb  [0:QW];

    logic                  r_vld [0:QW-1];
    logic [2:0][NW-1:0]    r_w   [0:QW-1];
    logic [LW-1:0]         r_den [0:QW-1];
    logic [SBW-1:0]        r_sb  [0:QW-1];

    assign w_vld[0] = i_vld;
    assign w_w[0]   = i_num;
    assign w_den[0] = i_den;
    assign w_sb[0]  = i_sb;

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [2:0][NW-1:0] w_nxt;

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [LW:0] w_t;
            logic [LW:0] w_diff;
            logic        w_ge;

            assign w_t    = w_w[j][l][NW-1:QW-1];
            assign w_ge   = (w_t >= {1'b0, w_den[j]});
            assign w_diff = w_t - {1'b0, w_den[j]};
            assign w_nxt[l] = {(w_ge ? w_diff[LW-1:0] : w_t[LW-1:0]),
                               w_w[j][l][QW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w[j]   <= w_nxt;
                r_den[j] <= w_den[j];
                r_sb[j]  <= w_sb[j];
            end
        end

        assign w_vld[j+1] = r_vld[j];
        assign w_w[j+1]   = r_w[j];
        assign w_den[j+1] = r_den[j];
        assign w_sb[j+1]  = r_sb[j];
    end

    for (genvar l = 0; l < 3; l++) begin : g_out
        assign o_quo[l] = w_w[QW][l][QW-1:0];
    end
    assign o_vld = w_vld[QW];
    assign o_sb  = w_sb[QW];

endmodule

### rtl/one_sided_spring_force_unit.sv
// One-sided spring force unit. A fully pipelined datapath: one item is accepted
// per cycle while the output is not stalled. Each item passes through the square
// root pipe (one root bit per stage, DATA_WIDTH+1 stages) and the divider (one
// quotient bit per stage, K_WIDTH+DATA_WIDTH+1-FRAC_BITS stages). A stall at the
// output freezes the whole pipe. Configuration is taken on i_cfg_we and must be
// written while idle.
// ----------------------------------------------------------------------------
// one_sided_spring_force_unit
// Bungee spring force -(d/L)*k*(L-rest) between a particle and its anchor.
// ----------------------------------------------------------------------------
`include "one_sided_spring_force_unit_assert.svh"

module one_sided_spring_force_unit #(
    parameter int DATA_WIDTH = ossf_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = ossf_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ossf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ossf_pkg::CFG_WIDTH-1:0]      i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [DATA_WIDTH-1:0]        i_own_x,
    input  logic signed [DATA_WIDTH-1:0]        i_own_y,
    input  logic signed [DATA_WIDTH-1:0]        i_own_z,
    input  logic signed [DATA_WIDTH-1:0]        i_anchor_x,
    input  logic signed [DATA_WIDTH-1:0]        i_anchor_y,
    input  logic signed [DATA_WIDTH-1:0]        i_anchor_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [DATA_WIDTH-1:0]        o_force_x,
    output logic signed [DATA_WIDTH-1:0]        o_force_y,
    output logic signed [DATA_WIDTH-1:0]        o_force_z,
    output logic                                o_applied
);

    localparam int KW  = ossf_pkg::K_WIDTH;
    localparam int RW  = ossf_pkg::REST_WIDTH;
    localparam int LW  = DATA_WIDTH + 1;
    localparam int SW  = 2 * LW;
    localparam int CW  = (SW > 2 * RW) ? SW : 2 * RW;
    localparam int EW  = ((LW > RW) ? LW : RW) + 1;
    localparam int QW  = KW + LW - FRAC_BITS;
    localparam int MH  = QW / 2;
    localparam int NW  = QW + LW;
    localparam int XW  = ((QW > DATA_WIDTH) ? QW : DATA_WIDTH) + 1;
    localparam int SB1 = 4 + 3 * LW;
    localparam int SB2 = 4;

    logic w_en;

    logic [KW-1:0]   r_k;
    logic [RW-1:0]   r_rest;
    logic [2*RW-1:0] r_rest_sq;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= ossf_pkg::K_RESET;
            r_rest <= ossf_pkg::REST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ossf_pkg::CFG_SPRING_STIFFNESS: r_k    <= i_cfg_wdata[KW-1:0];
                ossf_pkg::CFG_REST_LENGTH:      r_rest <= i_cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest_sq <= r_rest * r_rest;
    end

    // stage 0: separation
    logic signed [DATA_WIDTH-1:0] w_own [3];
    logic signed [DATA_WIDTH-1:0] w_anc [3];
    logic signed [LW-1:0]         w_d [3];
    logic              r0_vld;
    logic [2:0]        r0_neg;
    logic [LW-1:0]     r0_mg [3];

    assign w_own[0] = i_own_x;
    assign w_own[1] = i_own_y;
    assign w_own[2] = i_own_z;
    assign w_anc[0] = i_anchor_x;
    assign w_anc[1] = i_anchor_y;
    assign w_anc[2] = i_anchor_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld <= i_in_valid;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_sep
        assign w_d[i] = LW'(w_own[i]) - LW'(w_anc[i]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r0_neg[i] <= w_d[i][LW-1];
                r0_mg[i]  <= w_d[i][LW-1] ? LW'(-w_d[i]) : LW'(w_d[i]);
            end
        end
    end

    // stage 1: squares
    logic          r1_vld;
    logic [2:0]    r1_neg;
    logic [LW-1:0] r1_mg [3];
    logic [SW-1:0] r1_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_neg <= r0_neg;
            for (int i = 0; i < 3; i++) begin
                r1_mg[i] <= r0_mg[i];
                r1_sq[i] <= r0_mg[i] * r0_mg[i];
            end
        end
    end

    // stage 2: sum of squares, stretch test
    logic [SW+1:0]  w_sum;
    logic           r2_vld;
    logic [SW-1:0]  r2_s;
    logic [SB1-1:0] r2_sb;

    assign w_sum = (SW+2)'(r1_sq[0]) + (SW+2)'(r1_sq[1]) + (SW+2)'(r1_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_s  <= w_sum[SW-1:0];
            r2_sb <= {(CW'(w_sum[SW-1:0]) > CW'(r_rest_sq)), r1_neg,
                      r1_mg[2], r1_mg[1], r1_mg[0]};
        end
    end

    // square root
    logic           w_sq_vld;
    logic [LW-1:0]  w_len;
    logic [SB1-1:0] w_sq_sb;

    ossf_sqrt_pipe #(
        .LW  (LW),
        .SBW (SB1)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r2_vld),
        .i_rad   (r2_s),
        .i_sb    (r2_sb),
        .o_vld   (w_sq_vld),
        .o_root  (w_len),
        .o_sb    (w_sq_sb)
    );

    // stage 3: extension
    logic           r3_vld;
    logic [LW-1:0]  r3_len;
    logic [LW-1:0]  r3_ext;
    logic [SB1-1:0] r3_sb;
    logic [EW-1:0]  w_ext;

    assign w_ext = EW'(w_len) - EW'(r_rest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_len <= w_len;
            r3_ext <= w_ext[LW-1:0];
            r3_sb  <= w_sq_sb;
        end
    end

    // stage 4: k * ext
    logic              r4_vld;
    logic [LW-1:0]     r4_len;
    logic [KW+LW-1:0]  r4_kext;
    logic [SB1-1:0]    r4_sb;

    function automatic logic [KW+LW-1:0] r3_k_ext_mul(input logic [KW-1:0] a,
                                                      input logic [LW-1:0] b);
        r3_k_ext_mul = (KW+LW)'(a) * (KW+LW)'(b);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_len  <= r3_len;
            r4_kext <= r3_k_ext_mul(r_k, r3_ext);
            r4_sb   <= r3_sb;
        end
    end

    // stage 5: partial products mag * |d|
    logic [QW-1:0]       w_mag;
    logic                r5_vld;
    logic [LW-1:0]       r5_len;
    logic [SB2-1:0]      r5_sb;
    logic [MH+LW-1:0]    r5_pl [3];
    logic [QW-MH+LW-1:0] r5_ph [3];
    logic [LW-1:0]       w_mg [3];

    assign w_mag   = r4_kext[KW+LW-1:FRAC_BITS];
    assign w_mg[0] = r4_sb[LW-1:0];
    assign w_mg[1] = r4_sb[2*LW-1:LW];
    assign w_mg[2] = r4_sb[3*LW-1:2*LW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_len <= r4_len;
            r5_sb  <= r4_sb[SB1-1:3*LW];
            for (int i = 0; i < 3; i++) begin
                r5_pl[i] <= (MH+LW)'(w_mag[MH-1:0]) * (MH+LW)'(w_mg[i]);
                r5_ph[i] <= (QW-MH+LW)'(w_mag[QW-1:MH]) * (QW-MH+LW)'(w_mg[i]);
            end
        end
    end

    // stage 6: numerators
    logic               r6_vld;
    logic [LW-1:0]      r6_len;
    logic [SB2-1:0]     r6_sb;
    logic [2:0][NW-1:0] r6_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_len <= r5_len;
            r6_sb  <= r5_sb;
            for (int i = 0; i < 3; i++) begin
                r6_num[i] <= NW'(r5_pl[i]) + (NW'(r5_ph[i]) << MH);
            end
        end
    end

    // divide by length
    logic               w_dv_vld;
    logic [2:0][QW-1:0] w_quo;
    logic [SB2-1:0]     w_dv_sb;

    ossf_div_pipe #(
        .LW  (LW),
        .QW  (QW),
        .SBW (SB2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r6_vld),
        .i_num   (r6_num),
        .i_den   (r6_len),
        .i_sb    (r6_sb),
        .o_vld   (w_dv_vld),
        .o_quo   (w_quo),
        .o_sb    (w_dv_sb)
    );

    // output stage: sign, saturate, mask
    localparam logic [XW-1:0] POS_LIM = XW'((XW'(1) << (DATA_WIDTH - 1)) - XW'(1));

    logic                  w_app;
    logic [DATA_WIDTH-1:0] w_f [3];
    logic                  r_out_vld;
    logic [DATA_WIDTH-1:0] r_f [3];
    logic                  r_app;

    assign w_app = w_dv_sb[3];

    for (genvar i = 0; i < 3; i++) begin : g_sat
        logic [XW-1:0] w_q;
        assign w_q = XW'(w_quo[i]);
        always_comb begin
            if (!w_app) begin
                w_f[i] = '0;
            end else if (w_dv_sb[i]) begin
                w_f[i] = (w_q > POS_LIM) ? POS_LIM[DATA_WIDTH-1:0] : w_q[DATA_WIDTH-1:0];
            end else if (w_q > POS_LIM + XW'(1)) begin
                w_f[i] = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            end else begin
                w_f[i] = DATA_WIDTH'(XW'(0) - w_q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_app <= w_app;
            for (int i = 0; i < 3; i++) begin
                r_f[i] <= w_f[i];
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_applied   = r_app;
    assign o_force_x   = r_f[0];
    assign o_force_y   = r_f[1];
    assign o_force_z   = r_f[2];

    `OSSF_ASSERT_NOW(a_zero_when_slack, o_out_valid && !o_applied, (o_force_x == '0) && (o_force_y == '0) && (o_force_z == '0))
    `OSSF_ASSERT_NEXT(a_hold_on_stall, o_out_valid && !i_out_ready, o_out_valid && $stable(o_force_x) && $stable(o_applied))
    `OSSF_ASSERT_NEXT(a_item_enters, i_in_valid && o_in_ready, r0_vld)

endmodule

### sim/one_sided_spring_force_unit_tb.sv
// ----------------------------------------------------------------------------
// one_sided_spring_force_unit_tb
// Drives particle/anchor pairs through the spring force unit under random
// flow control and register settings, predicts each force from the math of
// the bungee spring, and compares every result in order.
// ----------------------------------------------------------------------------
class spring_force_board;
    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic        applied;
    } t_force;

    logic [31:0] stiffness;
    logic [30:0] rest_len;
    t_force      pending_forces[$];
    int          mismatches;

    function new();
        stiffness  = ossf_pkg::K_RESET;
        rest_len   = ossf_pkg::REST_RESET;
        mismatches = 0;
    endfunction

    function logic [63:0] isqrt(logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = 128'(c) * 128'(c);
            if (sq <= s) r = c;
        end
        return r;
    endfunction

    function void note_pair(logic signed [31:0] p[3], logic signed [31:0] q[3]);
        logic signed [32:0] d;
        logic [32:0]  mg[3];
        logic         neg[3];
        logic [127:0] s;
        logic [63:0]  len;
        logic [63:0]  ext;
        logic [127:0] mag;
        logic [191:0] quo;
        logic [31:0]  v[3];
        t_force       f;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            d = 33'(p[i]) - 33'(q[i]);
            neg[i] = d[32];
            mg[i] = neg[i] ? 33'(-d) : 33'(d);
            s += 128'(mg[i]) * 128'(mg[i]);
            v[i] = '0;
        end
        f.applied = s > 128'(rest_len) * 128'(rest_len);
        if (f.applied) begin
            len = isqrt(s);
            ext = len - 64'(rest_len);
            mag = (128'(stiffness) * 128'(ext)) >> 16;
            for (int i = 0; i < 3; i++) begin
                quo = (192'(mag) * 192'(mg[i])) / 192'(len);
                if (neg[i])
                    v[i] = (quo > 192'h7fff_ffff) ? 32'h7fff_ffff : quo[31:0];
                else
                    v[i] = (quo > 192'h8000_0000) ? 32'h8000_0000 : -quo[31:0];
            end
        end
        f.fx = v[0];
        f.fy = v[1];
        f.fz = v[2];
        pending_forces = {pending_forces, f};
    endfunction

    function void check_force(t_force got);
        t_force want;
        if (pending_forces.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending_forces.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp fx=%h fy=%h fz=%h ap=%b got fx=%h fy=%h fz=%h ap=%b",
                         want.fx, want.fy, want.fz, want.applied,
                         got.fx, got.fy, got.fz, got.applied);
        end
    endfunction
endclass

module one_sided_spring_force_unit_tb;

    localparam int LATENCY = 90;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [ossf_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [ossf_pkg::CFG_WIDTH-1:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic signed [31:0] i_own_x = '0, i_own_y = '0, i_own_z = '0;
    logic signed [31:0] i_anchor_x = '0, i_anchor_y = '0, i_anchor_z = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic signed [31:0] o_force_x, o_force_y, o_force_z;
    logic        o_applied;

    spring_force_board board;
    int  cycles = 0;
    int  hold_off = 0;

    one_sided_spring_force_unit i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("one_sided_spring_force_unit test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_force({o_force_x, o_force_y, o_force_z, o_applied});
    end

    initial begin
        int wait_n;
        wait (board != null);
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                i_out_ready <= 1'b0;
                hold_off <= hold_off - 1;
            end else if (i_out_ready && o_out_valid || !i_out_ready) begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                if ($urandom_range(0, 1) == 0) wait_n = 0;
                i_out_ready <= (wait_n == 0);
                if (wait_n != 0) begin
                    repeat (wait_n - 1) @(posedge i_clk);
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    task automatic write_reg(input logic [ossf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        if (idx == ossf_pkg::CFG_SPRING_STIFFNESS) board.stiffness = val;
        else board.rest_len = val[30:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending_forces.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic send_pair(input logic signed [31:0] p[3], input logic signed [31:0] q[3],
                             input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 17) : 0;
        if (gaps && $urandom_range(0, 1) == 0) gap = 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_own_x <= p[0]; i_own_y <= p[1]; i_own_z <= p[2];
        i_anchor_x <= q[0]; i_anchor_y <= q[1]; i_anchor_z <= q[2];
        do @(posedge i_clk); while (!o_in_ready);
        board.note_pair(p, q);
    endtask

    function automatic logic [31:0] pick_coord(int spread);
        unique case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return $urandom();
            default: return $urandom_range(0, 2 * spread) - spread;
        endcase
    endfunction

    task automatic random_pairs(int n, int spread, bit gaps);
        logic signed [31:0] p[3], q[3];
        for (int j = 0; j < n; j++) begin
            for (int i = 0; i < 3; i++) begin
                q[i] = pick_coord(spread);
                p[i] = ($urandom_range(0, 3) == 0) ? pick_coord(spread)
                     : q[i] + $urandom_range(0, 2 * spread) - spread;
            end
            send_pair(p, q, gaps);
        end
    endtask

    initial begin
        logic signed [31:0] p[3], q[3];
        logic [31:0] k_set[6];
        logic [31:0] r_set[6];
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, below rest, exactly rest, just over rest, extremes
        p = '{0, 0, 0}; q = '{0, 0, 0}; send_pair(p, q, 0);
        p = '{32'sh8000, 0, 0}; send_pair(p, q, 0);
        p = '{32'sh10000, 0, 0}; send_pair(p, q, 0);
        p = '{32'sh10001, 0, 0}; send_pair(p, q, 0);
        p = '{0, -32'sh10001, 0}; send_pair(p, q, 0);
        p = '{0, 0, 32'sh30000}; send_pair(p, q, 0);
        p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        q = '{32'sh80000000, 32'sh80000000, 32'sh80000000}; send_pair(p, q, 0);
        send_pair(q, p, 0);
        p = '{32'sh7fffffff, -32'sh50000, 32'sh20000}; q = '{0, 32'sh7fffffff, 0};
        send_pair(p, q, 0);
        drain();
        write_reg(ossf_pkg::CFG_SPRING_STIFFNESS, 32'hffff_ffff);
        write_reg(ossf_pkg::CFG_REST_LENGTH, 32'h0);
        p = '{1, 0, 0}; q = '{0, 0, 0}; send_pair(p, q, 0);
        p = '{32'sh7fffffff, 32'sh7fffffff, 0}; q = '{32'sh80000000, 0, 0};
        send_pair(p, q, 0);
        p = '{-32'sh100, 32'sh40, -32'sh3}; send_pair(p, q, 0);
        drain();

        k_set = '{32'h0, 32'hffff_ffff, 32'h0001_0000, 32'h0000_0001, 0, 0};
        r_set = '{32'h7fff_ffff, 32'h0, 32'h0001_0000, 32'h0, 0, 0};
        k_set[4] = $urandom(); r_set[4] = $urandom_range(0, 32'h0100_0000);
        k_set[5] = $urandom_range(0, 32'h0010_0000); r_set[5] = $urandom() >> 1;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(ossf_pkg::CFG_SPRING_STIFFNESS, k_set[ph]);
            write_reg(ossf_pkg::CFG_REST_LENGTH, r_set[ph]);
            random_pairs(180, 32'h0004_0000, 1);
            random_pairs(80, 32'h0400_0000, 0);
            if (ph == 2) begin
                fork
                    hold_off = 300;
                    random_pairs(150, 32'h0004_0000, 0);
                join
            end
            drain();
        end
        drain();
        if (board.mismatches == 0 && board.pending_forces.size() == 0)
            $display("one_sided_spring_force_unit test passed");
        else
            $display("one_sided_spring_force_unit test failed");
        $finish;
    end
endmodule
